@@ sv/prres_pkg.sv @@
`default_nettype none
package prres_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W  = 72;
   localparam int FRAC_W = 24;

   typedef enum logic [2:0] {
      OP_LOAD_BASIS = 3'd0,
      OP_LOAD_DUAL  = 3'd1,
      OP_LOAD_GINV  = 3'd2,
      OP_LOAD_PROJ  = 3'd3,
      OP_START      = 3'd4
   } op_type;

   typedef enum logic [0:0] {
      REG_VECTORS_USED = 1'd0,
      REG_LENGTH_USED  = 1'd1
   } reg_index_type;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] val;
   } round_type;

   // round to nearest, ties up, then saturate to q8.24
   function automatic round_type round_acc(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0]        t;
      logic signed [ACC_W-FRAC_W-1:0] s;
      round_type                      r;
      t = a + (ACC_W'(1) <<< (FRAC_W - 1));
      s = t[ACC_W-1:FRAC_W];
      if (s[ACC_W-FRAC_W-1:DATA_W-1] == '0 || s[ACC_W-FRAC_W-1:DATA_W-1] == '1) begin
         r.sat = 1'b0;
         r.val = s[DATA_W-1:0];
      end else begin
         r.sat = 1'b1;
         r.val = s[ACC_W-FRAC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/projection_residual.sv @@
`default_nettype none
// Projects a stored vector onto a loaded basis set and replaces it with the
// residual. Load items (basis, dual basis, inverse Gram entry, projectee
// element) are written straight into memory. A start item runs a sequencer around one
// shared registered 32x32 multiplier and single-port memory reads; it projects
// against n basis vectors, then emits len result items, each held until
// rsp_ready is seen, where n is vectors_used and len is length_used after
// clamping. Every rounding is nearest with ties up and
// saturates to q8.24; rsp_saturated reports any saturation during the run.
module projection_residual #(
   parameter int MAX_VECTORS = 16,
   parameter int VEC_LEN     = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [3:0]  req_vector_index,
   input  wire logic [5:0]  req_element_index,
   input  wire logic signed [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_element_index_res,
   output logic signed [31:0] rsp_value_res,
   output logic             rsp_last,
   output logic             rsp_saturated,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import prres_pkg::*;

   localparam int IW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int KW    = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
   localparam int BDEP  = MAX_VECTORS * VEC_LEN;
   localparam int BA_W  = (BDEP > 1) ? $clog2(BDEP) : 1;
   localparam int GDEP  = MAX_VECTORS * MAX_VECTORS;
   localparam int GA_W  = (GDEP > 1) ? $clog2(GDEP) : 1;

   typedef enum logic [13:0] {
      S_IDLE = 14'b00000000000001,
      S_DRD  = 14'b00000000000010,
      S_DMUL = 14'b00000000000100,
      S_DACC = 14'b00000000001000,
      S_DRND = 14'b00000000010000,
      S_GMUL = 14'b00000000100000,
      S_GACC = 14'b00000001000000,
      S_CRND = 14'b00000010000000,
      S_URD  = 14'b00000100000000,
      S_UMUL = 14'b00001000000000,
      S_USUB = 14'b00010000000000,
      S_UWR  = 14'b00100000000000,
      S_ORD  = 14'b01000000000000,
      S_OUT  = 14'b10000000000000
   } state_type;

   logic signed [DATA_W-1:0] basis_mem [BDEP];
   logic signed [DATA_W-1:0] dual_mem  [BDEP];
   logic signed [DATA_W-1:0] ginv_mem  [GDEP];
   logic signed [DATA_W-1:0] res_mem   [VEC_LEN];

   logic signed [DATA_W-1:0] basis_rd_ff, dual_rd_ff, ginv_rd_ff, res_rd_ff;

   state_type state_ff, state_in;
   logic [4:0]  vused_ff;
   logic [6:0]  lused_ff;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, lastv_ff, lastv_in;
   logic [KW-1:0] k_ff, k_in, lastk_ff, lastk_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, cacc_ff, cacc_in;
   logic signed [DATA_W-1:0] d_ff, d_in, c_ff, c_in;
   logic sat_ff, sat_in;

   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   round_type rnd_acc, rnd_cacc;

   logic req_fire, is_load;
   logic [BA_W-1:0] ld_vaddr, basis_raddr, dual_raddr;
   logic [GA_W-1:0] ld_gaddr, ginv_raddr;
   logic res_we;
   logic [KW-1:0] res_waddr;
   logic signed [DATA_W-1:0] res_wdata;
   logic [4:0] n_clamp;
   logic [6:0] len_clamp;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_load   = req_fire;
   assign csr_ready = 1'b1;

   assign ld_vaddr = BA_W'(BA_W'(req_vector_index) * BA_W'(VEC_LEN)) + BA_W'(req_element_index);
   assign ld_gaddr = GA_W'(GA_W'(req_vector_index) * GA_W'(MAX_VECTORS))
                     + GA_W'(req_element_index);
   assign basis_raddr = BA_W'(BA_W'(i_ff) * BA_W'(VEC_LEN)) + BA_W'(k_ff);
   assign dual_raddr  = BA_W'(BA_W'(j_ff) * BA_W'(VEC_LEN)) + BA_W'(k_ff);
   assign ginv_raddr  = GA_W'(GA_W'(i_ff) * GA_W'(MAX_VECTORS)) + GA_W'(j_ff);

   // memories
   always_ff @(posedge clock) begin
      if (is_load && req_operation == OP_LOAD_BASIS
          && 32'(req_vector_index) < MAX_VECTORS && 32'(req_element_index) < VEC_LEN) begin
         basis_mem[ld_vaddr] <= req_value;
      end
      basis_rd_ff <= basis_mem[basis_raddr];
   end

   always_ff @(posedge clock) begin
      if (is_load && req_operation == OP_LOAD_DUAL
          && 32'(req_vector_index) < MAX_VECTORS && 32'(req_element_index) < VEC_LEN) begin
         dual_mem[ld_vaddr] <= req_value;
      end
      dual_rd_ff <= dual_mem[dual_raddr];
   end

   always_ff @(posedge clock) begin
      if (is_load && req_operation == OP_LOAD_GINV
          && 32'(req_vector_index) < MAX_VECTORS && 32'(req_element_index) < MAX_VECTORS) begin
         ginv_mem[ld_gaddr] <= req_value;
      end
      ginv_rd_ff <= ginv_mem[ginv_raddr];
   end

   always_comb begin
      res_we    = 1'b0;
      res_waddr = k_ff;
      res_wdata = rnd_acc.val;
      if (is_load && req_operation == OP_LOAD_PROJ && 32'(req_element_index) < VEC_LEN) begin
         res_we    = 1'b1;
         res_waddr = KW'(req_element_index);
         res_wdata = req_value;
      end else if (state_ff == S_UWR) begin
         res_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_rd_ff <= res_mem[k_ff];
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = res_rd_ff;
      mul_b = dual_rd_ff;
      case (state_ff)
         S_GMUL: begin
            mul_a = ginv_rd_ff;
            mul_b = d_ff;
         end
         S_UMUL: begin
            mul_a = c_ff;
            mul_b = basis_rd_ff;
         end
         default: begin
            mul_a = res_rd_ff;
            mul_b = dual_rd_ff;
         end
      endcase
   end

   prres_mac u_mac (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign rnd_acc  = round_acc(acc_ff);
   assign rnd_cacc = round_acc(cacc_ff);

   always_comb begin
      if (vused_ff == 5'd0) n_clamp = 5'd1;
      else if (32'(vused_ff) > MAX_VECTORS) n_clamp = 5'(MAX_VECTORS);
      else n_clamp = vused_ff;
      if (lused_ff == 7'd0) len_clamp = 7'd1;
      else if (32'(lused_ff) > VEC_LEN) len_clamp = 7'(VEC_LEN);
      else len_clamp = lused_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      lastv_in = lastv_ff;
      lastk_in = lastk_ff;
      acc_in   = acc_ff;
      cacc_in  = cacc_ff;
      d_in     = d_ff;
      c_in     = c_ff;
      sat_in   = sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_operation == OP_START) begin
               lastv_in = IW'(n_clamp - 5'd1);
               lastk_in = KW'(len_clamp - 7'd1);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               cacc_in  = '0;
               sat_in   = 1'b0;
               state_in = S_DRD;
            end
         end
         S_DRD:  state_in = S_DMUL;
         S_DMUL: state_in = S_DACC;
         S_DACC: begin
            acc_in = acc_ff + ACC_W'(prod);
            if (k_ff == lastk_ff) begin
               state_in = S_DRND;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_DRD;
            end
         end
         S_DRND: begin
            d_in     = rnd_acc.val;
            sat_in   = sat_ff | rnd_acc.sat;
            state_in = S_GMUL;
         end
         S_GMUL: state_in = S_GACC;
         S_GACC: begin
            cacc_in = cacc_ff + ACC_W'(prod);
            acc_in  = '0;
            k_in    = '0;
            if (j_ff == lastv_ff) begin
               state_in = S_CRND;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = S_DRD;
            end
         end
         S_CRND: begin
            c_in     = rnd_cacc.val;
            sat_in   = sat_ff | rnd_cacc.sat;
            k_in     = '0;
            state_in = S_URD;
         end
         S_URD:  state_in = S_UMUL;
         S_UMUL: state_in = S_USUB;
         S_USUB: begin
            acc_in   = (ACC_W'(res_rd_ff) <<< FRAC_W) - ACC_W'(prod);
            state_in = S_UWR;
         end
         S_UWR: begin
            sat_in = sat_ff | rnd_acc.sat;
            if (k_ff == lastk_ff) begin
               k_in = '0;
               if (i_ff == lastv_ff) begin
                  state_in = S_ORD;
               end else begin
                  i_in     = i_ff + IW'(1);
                  j_in     = '0;
                  acc_in   = '0;
                  cacc_in  = '0;
                  state_in = S_DRD;
               end
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_URD;
            end
         end
         S_ORD: state_in = S_OUT;
         S_OUT: begin
            if (rsp_ready) begin
               if (k_ff == lastk_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vused_ff <= 5'd1;
         lused_ff <= 7'd64;
         sat_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         lastv_ff <= '0;
         lastk_ff <= '0;
      end else begin
         state_ff <= state_in;
         sat_ff   <= sat_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         lastv_ff <= lastv_in;
         lastk_ff <= lastk_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_VECTORS_USED) vused_ff <= csr_data[4:0];
            else lused_ff <= csr_data[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      cacc_ff <= cacc_in;
      d_ff    <= d_in;
      c_ff    <= c_in;
   end

   assign rsp_valid             = (state_ff == S_OUT);
   assign rsp_element_index_res = 6'(k_ff);
   assign rsp_value_res         = res_rd_ff;
   assign rsp_last              = (k_ff == lastk_ff);
   assign rsp_saturated         = sat_ff;

endmodule
`default_nettype wire

@@ sv/prres_mac.sv @@
`default_nettype none
module prres_mac (
   input  wire logic                                clock,
   input  wire logic signed [prres_pkg::DATA_W-1:0] a,
   input  wire logic signed [prres_pkg::DATA_W-1:0] b,
   output logic signed [prres_pkg::PROD_W-1:0]      prod
);
   import prres_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(a) * PROD_W'(b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

@@ verif/tb_projection_residual.sv @@
`default_nettype none
module tb_projection_residual;
   import prres_pkg::*;

   localparam int          NVEC       = 16;
   localparam int          NLEN       = 64;
   localparam int          IDLE_LIMIT = 400000;
   localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
   localparam int          NUM_SPARE  = 3;

   typedef struct {
      logic [5:0]         idx;
      logic signed [31:0] val;
      logic               last;
      logic               sat;
   } residual_elem_type;

   class residual_scoreboard;
      logic signed [31:0] basis [NVEC][NLEN];
      logic signed [31:0] dual  [NVEC][NLEN];
      logic signed [31:0] ginv  [NVEC][NVEC];
      logic signed [31:0] resid [NLEN];
      bit                 basis_ok [NVEC][NLEN];
      bit                 dual_ok  [NVEC][NLEN];
      bit                 ginv_ok  [NVEC][NVEC];
      bit                 resid_ok [NLEN];
      bit                 sat_flag;
      int                 vec_reg = 1;
      int                 len_reg = 64;
      residual_elem_type  pending_q[$];
      int                 errors;

      function void write_reg(reg_index_type idx, logic [7:0] data);
         if (idx == REG_VECTORS_USED) vec_reg = int'(data & 8'h1f);
         else len_reg = int'(data & 8'h7f);
      endfunction

      function int num_vectors();
         return (vec_reg < 1) ? 1 : (vec_reg > NVEC) ? NVEC : vec_reg;
      endfunction

      function int num_elems();
         return (len_reg < 1) ? 1 : (len_reg > NLEN) ? NLEN : len_reg;
      endfunction

      // nearest, ties up, saturate to q8.24
      function logic signed [31:0] round_q(logic signed [127:0] a);
         logic signed [127:0] s;
         s = (a + 128'sd8388608) >>> 24;
         if (s > 128'sd2147483647) begin
            sat_flag = 1'b1;
            return 32'sh7fffffff;
         end
         if (s < -128'sd2147483648) begin
            sat_flag = 1'b1;
            return 32'sh80000000;
         end
         return s[31:0];
      endfunction

      function void note_item(logic [2:0] op, logic [3:0] vi, logic [5:0] ei,
                              logic signed [31:0] v);
         int                  n, len;
         logic signed [127:0] acc, cacc;
         logic signed [31:0]  d, c;
         case (op)
            OP_LOAD_BASIS: begin
               basis[vi][ei] = v; basis_ok[vi][ei] = 1;
            end
            OP_LOAD_DUAL: begin
               dual[vi][ei] = v; dual_ok[vi][ei] = 1;
            end
            OP_LOAD_GINV: begin
               if (ei < NVEC) begin
                  ginv[vi][ei] = v; ginv_ok[vi][ei] = 1;
               end
            end
            OP_LOAD_PROJ: begin
               resid[ei] = v; resid_ok[ei] = 1;
            end
            OP_START: begin
               n = num_vectors();
               len = num_elems();
               sat_flag = 0;
               for (int i = 0; i < n; i++) begin
                  cacc = 0;
                  for (int j = 0; j < n; j++) begin
                     acc = 0;
                     for (int k = 0; k < len; k++)
                        acc += longint'(resid[k]) * longint'(dual[j][k]);
                     d = round_q(acc);
                     cacc += longint'(ginv[i][j]) * longint'(d);
                  end
                  c = round_q(cacc);
                  for (int k = 0; k < len; k++) begin
                     acc = (longint'(resid[k]) <<< 24) - longint'(c) * longint'(basis[i][k]);
                     resid[k] = round_q(acc);
                  end
               end
               for (int k = 0; k < len; k++)
                  pending_q = {pending_q,
                               residual_elem_type'{6'(k), resid[k], k == len - 1, sat_flag}};
            end
            default: ;
         endcase
      endfunction

      function void check(logic [5:0] idx, logic signed [31:0] val, logic last, logic sat);
         residual_elem_type e;
         if (pending_q.size() == 0) begin
            $error("unexpected result item: index %0d value %h", idx, val);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (idx !== e.idx) begin
            $error("element_index_res: expected %0d, got %0d", e.idx, idx); errors++;
         end
         if (val !== e.val) begin
            $error("value_res: expected %h, got %h", e.val, val); errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %b, got %b", e.last, last); errors++;
         end
         if (sat !== e.sat) begin
            $error("saturated: expected %b, got %b", e.sat, sat); errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [2:0]         req_operation = '0;
   logic [3:0]         req_vector_index = '0;
   logic [5:0]         req_element_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [5:0]         rsp_element_index_res;
   logic signed [31:0] rsp_value_res;
   logic               rsp_last;
   logic               rsp_saturated;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [0:0]         csr_index = '0;
   logic [7:0]         csr_data = '0;

   residual_scoreboard sb = new();
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;

   projection_residual dut (.*);

   always #6 clock = ~clock;

   // receiver stall pattern, changes mode every so often
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check(rsp_element_index_res, rsp_value_res, rsp_last, rsp_saturated);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 0;
               default: return -1;
            endcase
         default: return $signed($urandom) >>> $urandom_range(4, 14);
      endcase
   endfunction

   // tasks start and end just after a falling edge
   task automatic send(logic [2:0] op, logic [3:0] vi, logic [5:0] ei, logic signed [31:0] v);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid = 1;
      req_operation = op;
      req_vector_index = vi;
      req_element_index = ei;
      req_value = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(op, vi, ei, v);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid = 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [7:0] data);
      wait_idle();
      csr_valid = 1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // load whatever a start would read that has not been written yet
   task automatic fill_then_start();
      int n, len;
      n = sb.num_vectors();
      len = sb.num_elems();
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < len; k++) begin
            if (!sb.basis_ok[i][k]) send(OP_LOAD_BASIS, 4'(i), 6'(k), rand_value());
            if (!sb.dual_ok[i][k]) send(OP_LOAD_DUAL, 4'(i), 6'(k), rand_value());
         end
         for (int j = 0; j < n; j++)
            if (!sb.ginv_ok[i][j]) send(OP_LOAD_GINV, 4'(i), 6'(j), rand_value());
      end
      for (int k = 0; k < len; k++)
         if (!sb.resid_ok[k]) send(OP_LOAD_PROJ, 4'($urandom), 6'(k), rand_value());
      send(OP_START, 4'($urandom), 6'($urandom), $urandom);
   endtask

   initial begin
      int n, len, r;
      repeat (3) @(negedge clock);
      reset = 0;

      // directed part
      write_csr(REG_VECTORS_USED, 8'd2);
      write_csr(REG_LENGTH_USED, 8'd4);
      fill_then_start();
      send(OP_START, 4'hf, 6'h3f, 32'sh7fffffff);      // residual projected again
      for (int k = 0; k < NUM_SPARE; k++)
         send(OP_SPARE_FIRST + 3'(k), 4'hf, 6'h3f, -32'sd1);
      send(OP_LOAD_GINV, 4'd1, 6'd40, 32'sh7fffffff);  // column out of range
      send(OP_LOAD_PROJ, 4'd9, 6'd0, 32'sh01000000);   // vector index ignored
      send(OP_START, 4'd0, 6'd0, 32'sd0);
      send(OP_LOAD_PROJ, 4'd0, 6'd0, 32'sh7fffffff);
      send(OP_LOAD_DUAL, 4'd0, 6'd0, 32'sh80000000);
      send(OP_LOAD_GINV, 4'd0, 6'd0, 32'sh7fffffff);
      send(OP_START, 4'd0, 6'd0, 32'sd0);              // saturating run
      write_csr(REG_VECTORS_USED, 8'd0);
      write_csr(REG_LENGTH_USED, 8'd0);
      fill_then_start();

      // random part, small sizes mostly
      write_csr(REG_VECTORS_USED, 8'd3);
      write_csr(REG_LENGTH_USED, 8'd8);
      for (int it = 0; it < 180; it++) begin
         n = sb.num_vectors();
         len = sb.num_elems();
         r = $urandom_range(0, 99);
         if (r < 4) begin
            write_csr(REG_VECTORS_USED,
                      ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4)));
            write_csr(REG_LENGTH_USED,
                      ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 16)));
         end else if (r < 14) begin
            fill_then_start();
         end else if (r < 18) begin
            send(OP_SPARE_FIRST + 3'($urandom_range(0, NUM_SPARE - 1)), 4'($urandom),
                 6'($urandom), $urandom);
         end else if (r < 20) begin
            send(OP_LOAD_GINV, 4'($urandom), 6'($urandom_range(NVEC, NLEN - 1)), $urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: send(OP_LOAD_BASIS, 4'($urandom_range(0, n - 1)),
                       6'($urandom_range(0, len - 1)), rand_value());
               1: send(OP_LOAD_DUAL, 4'($urandom_range(0, n - 1)),
                       6'($urandom_range(0, len - 1)), rand_value());
               2: send(OP_LOAD_GINV, 4'($urandom_range(0, n - 1)),
                       6'($urandom_range(0, n - 1)), rand_value());
               default: send(OP_LOAD_PROJ, 4'($urandom), 6'($urandom_range(0, len - 1)),
                             rand_value());
            endcase
         end
      end
      fill_then_start();

      wait_idle();
      repeat (20) @(negedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
